### hdl/thd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package thd_pkg;

    // Header format
    localparam logic [7:0]  FLAGS_CHECK  = 8'hc0;
    localparam logic [7:0]  FLAGS_MASK   = 8'hc1;
    localparam logic [2:0]  FIELD_MASK3  = 3'd7;
    localparam logic [31:0] CANCEL_MAGIC = 32'h18181818;
    localparam logic [7:0]  MAGIC_BYTE   = CANCEL_MAGIC[7:0];

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_NAME      = 3'd1;
    localparam logic [2:0] KIND_ACCEPT    = 3'd2;
    localparam logic [2:0] KIND_CANCEL    = 3'd3;
    localparam logic [2:0] KIND_MALFORMED = 3'd4;

    // Parser phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_NAME    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DROP    = 2'd3;

    // Result buffering
    localparam int MAX_RESULTS   = 5;
    localparam int PARSE_RESULTS = 2;
    localparam int REPLAY_MAX    = 3;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W         = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [63:0] offset;
        logic        done;
    } result_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [3:0]  hc;        // header bytes seen
        logic [3:0]  sbc;       // size byte count, 1..8
        logic [1:0]  nbc;       // name-length byte count, 0..3
        logic [63:0] total;
        logic [15:0] nlen;
        logic [15:0] nseen;
        logic [63:0] progress;
    } state_t;

    typedef struct packed {
        logic             fire;
        logic [CNT_W-1:0] count;
        logic [63:0]      total;
        logic [15:0]      nlen;
    } buf_load_t;

    function automatic result_t event_res(input logic [2:0] k);
        result_t r;
        r.kind   = k;
        r.value  = 8'd0;
        r.offset = 64'd0;
        r.done   = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/thd_parse.sv
`timescale 1ns / 1ps
`default_nettype none

// One byte through the header/name/payload parser. Up to two results.
module thd_parse (
    input  thd_pkg::state_t  st,
    input  logic [7:0]       data,
    input  logic             first_mark,
    input  logic             last_mark,
    output thd_pkg::state_t  st_next,
    output thd_pkg::result_t res [thd_pkg::PARSE_RESULTS],
    output logic [1:0]       res_count
);
    import thd_pkg::*;

    always_comb
    begin
        state_t      s;
        result_t     m0;
        result_t     m1;
        logic        pre_v;
        logic        m0_v;
        logic        m1_v;
        logic        quiet;
        logic        fin;
        logic [3:0]  idx;
        logic [3:0]  jdx;
        logic [3:0]  hc_inc;
        logic [3:0]  hdr_len;
        logic [15:0] seen_inc;
        logic [63:0] prog_inc;

        s        = st;
        m0       = event_res(KIND_MALFORMED);
        m1       = event_res(KIND_MALFORMED);
        pre_v    = 1'b0;
        m0_v     = 1'b0;
        m1_v     = 1'b0;
        fin      = 1'b0;
        idx      = 4'd0;
        jdx      = 4'd0;
        hc_inc   = 4'd0;
        hdr_len  = 4'd0;
        seen_inc = 16'd0;
        prog_inc = 64'd0;

        // dropping: only a message start or the last byte of a message wakes us
        quiet = (s.phase == PH_DROP) && !first_mark;
        if (quiet && last_mark)
        begin
            s.phase = PH_HEADER;
        end
        if (s.phase == PH_DROP && first_mark)
        begin
            s.phase = PH_HEADER;
            s.hc    = 4'd0;
        end

        if (!quiet)
        begin
            // new message cuts a partial header or name
            if (s.phase == PH_NAME && first_mark)
            begin
                pre_v   = 1'b1;
                s.phase = PH_HEADER;
                s.hc    = 4'd0;
            end
            else if (s.phase == PH_HEADER && first_mark && s.hc != 4'd0)
            begin
                pre_v = 1'b1;
                s.hc  = 4'd0;
            end

            unique case (s.phase)
                PH_PAYLOAD:
                begin
                    prog_inc  = s.progress + 64'd1;
                    fin       = (prog_inc == s.total);
                    m0_v      = 1'b1;
                    m0.kind   = KIND_PAYLOAD;
                    m0.value  = data;
                    m0.offset = s.progress;
                    m0.done   = fin;
                    s.progress = prog_inc;
                    if (fin)
                    begin
                        s.phase = PH_HEADER;
                        s.hc    = 4'd0;
                    end
                end
                PH_NAME:
                begin
                    m0_v      = 1'b1;
                    m0.kind   = KIND_NAME;
                    m0.value  = data;
                    m0.offset = 64'(s.nseen);
                    seen_inc  = s.nseen + 16'd1;
                    s.nseen   = seen_inc;
                    if (seen_inc >= s.nlen)
                    begin
                        fin        = (s.total == 64'd0);
                        m1_v       = 1'b1;
                        m1         = event_res(KIND_ACCEPT);
                        m1.done    = fin;
                        s.progress = 64'd0;
                        s.hc       = 4'd0;
                        s.phase    = fin ? PH_HEADER : PH_PAYLOAD;
                    end
                    else if (last_mark)
                    begin
                        m1_v    = 1'b1;
                        s.phase = PH_HEADER;
                        s.hc    = 4'd0;
                    end
                end
                default:
                begin
                    s.phase = PH_HEADER;
                    if (s.hc == 4'd0)
                    begin
                        if (((data & FLAGS_MASK) != FLAGS_CHECK) || last_mark)
                        begin
                            m0_v    = 1'b1;
                            s.phase = last_mark ? PH_HEADER : PH_DROP;
                        end
                        else
                        begin
                            s.sbc   = {1'b0, data[3:1] & FIELD_MASK3} + 4'd1;
                            s.nbc   = data[5:4];
                            s.total = 64'd0;
                            s.nlen  = 16'd0;
                            s.hc    = 4'd1;
                        end
                    end
                    else
                    begin
                        idx = s.hc - 4'd1;
                        if (idx < s.sbc)
                        begin
                            s.total = s.total | (64'(data) << {idx[2:0], 3'b000});
                        end
                        else
                        begin
                            jdx = idx - s.sbc;
                            if (jdx == 4'd0)
                            begin
                                s.nlen = s.nlen | {8'd0, data};
                            end
                            else if (jdx == 4'd1)
                            begin
                                s.nlen = s.nlen | {data, 8'd0};
                            end
                        end
                        hc_inc  = s.hc + 4'd1;
                        s.hc    = hc_inc;
                        hdr_len = 4'd1 + s.sbc + {2'b00, s.nbc};
                        if (hc_inc >= hdr_len)
                        begin
                            if (s.nlen != 16'd0)
                            begin
                                if (last_mark)
                                begin
                                    m0_v = 1'b1;
                                    s.hc = 4'd0;
                                end
                                else
                                begin
                                    s.phase = PH_NAME;
                                    s.nseen = 16'd0;
                                end
                            end
                            else if (last_mark && hc_inc < 4'd3)
                            begin
                                m0_v = 1'b1;
                                s.hc = 4'd0;
                            end
                            else
                            begin
                                fin        = (s.total == 64'd0);
                                m0_v       = 1'b1;
                                m0         = event_res(KIND_ACCEPT);
                                m0.done    = fin;
                                s.progress = 64'd0;
                                s.hc       = 4'd0;
                                s.phase    = fin ? PH_HEADER : PH_PAYLOAD;
                            end
                        end
                        else if (last_mark)
                        begin
                            m0_v = 1'b1;
                            s.hc = 4'd0;
                        end
                    end
                end
            endcase
        end

        st_next   = s;
        res[0]    = pre_v ? event_res(KIND_MALFORMED) : m0;
        res[1]    = pre_v ? m0 : m1;
        res_count = {1'b0, pre_v} + {1'b0, m0_v} + {1'b0, m1_v};
    end

endmodule

`default_nettype wire

### hdl/thd_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

// Result buffer: loaded with one item's results, drained one per cycle unless stalled.
module thd_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  thd_pkg::buf_load_t  load,
    input  thd_pkg::result_t    entries [thd_pkg::MAX_RESULTS],
    output logic                free,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          kind,
    output logic [7:0]          value,
    output logic [63:0]         offset,
    output logic [63:0]         total_size,
    output logic [15:0]         name_length,
    output logic                done_res,
    output logic                last
);
    import thd_pkg::*;

    result_t          ent_reg [MAX_RESULTS];
    logic [63:0]      tot_reg;
    logic [15:0]      nlen_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] rd_reg;
    logic [CNT_W-1:0] rd_next;
    logic             pop;
    logic             at_end;
    result_t          head;

    assign out_valid = (rd_reg < cnt_reg);
    assign pop       = out_valid && !out_stall;
    assign at_end    = ((rd_reg + CNT_W'(1)) == cnt_reg);
    assign free      = !out_valid || (pop && at_end);

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load.fire)
        begin
            cnt_next = load.count;
            rd_next  = '0;
        end
        else if (pop)
        begin
            rd_next = rd_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.fire)
        begin
            ent_reg  <= entries;
            tot_reg  <= load.total;
            nlen_reg <= load.nlen;
        end
    end

    assign head        = out_valid ? ent_reg[rd_reg[IDX_W-1:0]] : event_res(KIND_PAYLOAD);
    assign kind        = head.kind;
    assign value       = head.value;
    assign offset      = head.offset;
    assign done_res    = head.done;
    assign total_size  = (head.kind == KIND_ACCEPT) ? tot_reg : 64'd0;
    assign name_length = (head.kind == KIND_ACCEPT) ? nlen_reg : 16'd0;
    assign last        = out_valid && at_end;

endmodule

`default_nettype wire

### hdl/transfer_header_deframer.sv
// Path: a request passes the input register, then the result buffer, before its
// first result is presented; a busy result buffer can hold it between the two.
// Throughput: one request per cycle while each gives at most one result and out_stall
// is low; a request giving n results (up to 5) holds the buffer until all are taken.
// Reset: rst_n asynchronous, active low; clears parser phase, counters, hold count
// and both handshake stages. No clearing pass; in_stall stays low through release.
`timescale 1ns / 1ps
`default_nettype none

module transfer_header_deframer (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        first_of_message,
    input  logic        last_of_message,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  value,
    output logic [63:0] offset,
    output logic [63:0] total_size,
    output logic [15:0] name_length,
    output logic        done_res,
    output logic        last
);
    import thd_pkg::*;

    // ------------------------------------------------------------------
    // Input register. A request is worked on the cycle after it lands
    // here, as soon as the result buffer has room for its results.
    // ------------------------------------------------------------------
    logic       in_v_reg;
    logic       in_v_next;
    logic [7:0] b_reg;
    logic       f_reg;
    logic       l_reg;
    logic       fire;
    logic       buf_free;
    logic       in_take;

    assign fire     = in_v_reg && buf_free;
    assign in_stall = in_v_reg && !buf_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (in_take)
        begin
            in_v_next = 1'b1;
        end
        else if (fire)
        begin
            in_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            b_reg <= byte_value;
            f_reg <= first_of_message;
            l_reg <= last_of_message;
        end
    end

    // ------------------------------------------------------------------
    // Parser state and cancel hold count. Held bytes are always the
    // magic byte, so only how many are held is kept.
    // ------------------------------------------------------------------
    state_t     st_reg;
    state_t     st_next;
    logic [1:0] hold_cnt_reg;
    logic [1:0] hold_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= '0;
            hold_cnt_reg <= 2'd0;
        end
        else if (fire)
        begin
            st_reg       <= st_next;
            hold_cnt_reg <= hold_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Hold decisions on the registered request.
    // ------------------------------------------------------------------
    logic held;
    logic is_magic;
    logic cancel;
    logic hold_more;
    logic do_replay;
    logic hold_start;
    logic parse_run;

    assign held      = (hold_cnt_reg != 2'd0);
    assign is_magic  = (b_reg == MAGIC_BYTE);
    // fourth magic byte: the open transfer is cancelled
    assign cancel    = held && !f_reg && is_magic && (hold_cnt_reg == 2'(REPLAY_MAX));
    // another magic byte, still inside the four
    assign hold_more = held && !f_reg && is_magic && !l_reg && !cancel;
    // anything else while holding: held bytes go back in as payload
    assign do_replay = held && !cancel && !hold_more;

    // ------------------------------------------------------------------
    // Replay of held bytes. Each is a plain payload byte until the
    // transfer completes; the next magic byte then fails the flags check
    // and the rest of the held bytes fall into the drop phase.
    // ------------------------------------------------------------------
    state_t  st_rp;
    result_t rp [REPLAY_MAX];
    logic [REPLAY_MAX-1:0] rp_v;

    always_comb
    begin
        logic [63:0] nxt;

        st_rp = st_reg;
        rp_v  = '0;
        nxt   = 64'd0;
        for (int i = 0; i < REPLAY_MAX; i++)
        begin
            rp[i] = event_res(KIND_MALFORMED);
            if (do_replay && (2'(i) < hold_cnt_reg))
            begin
                if (st_rp.phase == PH_PAYLOAD)
                begin
                    nxt          = st_reg.progress + 64'(i + 1);
                    rp_v[i]      = 1'b1;
                    rp[i].kind   = KIND_PAYLOAD;
                    rp[i].value  = MAGIC_BYTE;
                    rp[i].offset = st_reg.progress + 64'(i);
                    rp[i].done   = (nxt == st_reg.total);
                    st_rp.progress = nxt;
                    if (nxt == st_reg.total)
                    begin
                        st_rp.phase = PH_HEADER;
                        st_rp.hc    = 4'd0;
                    end
                end
                else if (st_rp.phase == PH_HEADER)
                begin
                    rp_v[i]     = 1'b1;
                    st_rp.phase = PH_DROP;
                    st_rp.hc    = 4'd0;
                end
            end
        end
    end

    // A message start in payload opening with the magic byte begins a hold.
    // This can also follow a replay that leaves the transfer open.
    assign hold_start = (st_rp.phase == PH_PAYLOAD) && f_reg && is_magic && !l_reg;
    assign parse_run  = !cancel && !hold_more && !hold_start;

    // ------------------------------------------------------------------
    // Current byte through the parser, from the post-replay state.
    // ------------------------------------------------------------------
    state_t     st_parse;
    result_t    pres [PARSE_RESULTS];
    logic [1:0] pres_count;

    thd_parse u_parse (
        .st         (st_rp),
        .data       (b_reg),
        .first_mark (f_reg),
        .last_mark  (l_reg),
        .st_next    (st_parse),
        .res        (pres),
        .res_count  (pres_count)
    );

    // ------------------------------------------------------------------
    // Next state and result list: replay results, then the current
    // byte's, packed into the buffer in order.
    // ------------------------------------------------------------------
    result_t   ent [MAX_RESULTS];
    buf_load_t load;

    always_comb
    begin
        logic [CNT_W-1:0] n;
        result_t cand [REPLAY_MAX + PARSE_RESULTS + 1];
        logic [REPLAY_MAX+PARSE_RESULTS:0] cand_v;

        st_next       = st_reg;
        hold_cnt_next = 2'd0;
        if (cancel)
        begin
            st_next.phase    = PH_HEADER;
            st_next.hc       = 4'd0;
            st_next.progress = 64'd0;
        end
        else if (hold_more)
        begin
            hold_cnt_next = hold_cnt_reg + 2'd1;
        end
        else if (hold_start)
        begin
            st_next       = st_rp;
            hold_cnt_next = 2'd1;
        end
        else
        begin
            st_next = st_parse;
        end

        for (int i = 0; i < REPLAY_MAX; i++)
        begin
            cand[i]   = rp[i];
            cand_v[i] = rp_v[i];
        end
        for (int i = 0; i < PARSE_RESULTS; i++)
        begin
            cand[REPLAY_MAX + i]   = pres[i];
            cand_v[REPLAY_MAX + i] = parse_run && (2'(i) < pres_count);
        end
        cand[REPLAY_MAX + PARSE_RESULTS]   = event_res(KIND_CANCEL);
        cand_v[REPLAY_MAX + PARSE_RESULTS] = cancel;

        n = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            ent[i] = event_res(KIND_PAYLOAD);
        end
        for (int i = 0; i <= REPLAY_MAX + PARSE_RESULTS; i++)
        begin
            if (cand_v[i] && (n < CNT_W'(MAX_RESULTS)))
            begin
                ent[n[IDX_W-1:0]] = cand[i];
                n = n + CNT_W'(1);
            end
        end

        load.fire  = fire;
        load.count = n;
        load.total = st_parse.total;
        load.nlen  = st_parse.nlen;
    end

    // ------------------------------------------------------------------
    // Result buffer and output handshake. Last is flagged on the final
    // entry of each request's list.
    // ------------------------------------------------------------------
    thd_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .entries     (ent),
        .free        (buf_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value       (value),
        .offset      (offset),
        .total_size  (total_size),
        .name_length (name_length),
        .done_res    (done_res),
        .last        (last)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // bytes are only ever held against an open transfer
    a_hold_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_cnt_reg != 2'd0) |-> (st_reg.phase == PH_PAYLOAD))
        else $error("cancel hold outside an open transfer");

    // an open transfer always has bytes left
    a_progress_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_PAYLOAD) |-> (st_reg.progress < st_reg.total))
        else $error("transfer progress reached total while still open");

    // header accepted and cancelled close the result list of their request
    a_event_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((kind == KIND_ACCEPT) || (kind == KIND_CANCEL))) |-> last)
        else $error("accept or cancel result not flagged last");

endmodule

`default_nettype wire
